>>> hw/rtl/score_map_argmax_box_decode_unit_assert.svh
// Assertion macros for the score map argmax box decode unit.
`ifndef SCORE_MAP_ARGMAX_BOX_DECODE_UNIT_ASSERT_SVH
`define SCORE_MAP_ARGMAX_BOX_DECODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SMAB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smab check failed");
`define SMAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smab check failed");
`else
`define SMAB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMAB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/smab_pkg.sv
// Shared constants and types of the score map argmax box decode unit.
package smab_pkg;

  localparam int unsigned MAX_GRID_DEF = 64;
  localparam int unsigned FRAC_W       = 16;
  localparam int unsigned SCORE_W      = 16;
  localparam int unsigned GRID_W       = 7;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned STEP_W       = $clog2(FRAC_W);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(FRAC_W - 1);
  localparam logic [GRID_W-1:0] GRID_RST  = GRID_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic take_cell;
    logic snap;
    logic div_step;
  } dp_cmd_t;

  typedef struct packed {
    logic last_cell;
  } dp_status_t;

endpackage

>>> hw/rtl/smab_if.sv
// Channel interfaces: cell input, box output and grid size configuration.
interface smab_cell_if;
  logic                                valid;
  logic                                ready;
  logic signed [smab_pkg::SCORE_W-1:0] cell_score;
  logic        [smab_pkg::FRAC_W-1:0]  cell_width;
  logic        [smab_pkg::FRAC_W-1:0]  cell_height;
  logic        [smab_pkg::FRAC_W-1:0]  cell_offset_x;
  logic        [smab_pkg::FRAC_W-1:0]  cell_offset_y;

  modport source (
    output valid, cell_score, cell_width, cell_height, cell_offset_x, cell_offset_y,
    input  ready
  );
  modport sink (
    input  valid, cell_score, cell_width, cell_height, cell_offset_x, cell_offset_y,
    output ready
  );
endinterface

interface smab_box_if;
  logic                                valid;
  logic                                ready;
  logic        [smab_pkg::FRAC_W-1:0]  center_x;
  logic        [smab_pkg::FRAC_W-1:0]  center_y;
  logic        [smab_pkg::FRAC_W-1:0]  box_width;
  logic        [smab_pkg::FRAC_W-1:0]  box_height;
  logic signed [smab_pkg::SCORE_W-1:0] peak_score;
  logic        [smab_pkg::IDX_W-1:0]   peak_index;

  modport source (
    output valid, center_x, center_y, box_width, box_height, peak_score, peak_index,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, box_width, box_height, peak_score, peak_index,
    output ready
  );
endinterface

interface smab_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [smab_pkg::GRID_W-1:0]   grid_size;

  modport source (
    output valid, grid_size,
    input  ready
  );
  modport sink (
    input  valid, grid_size,
    output ready
  );
endinterface

>>> hw/rtl/smab_div.sv
// Bit-serial restoring divider for one center coordinate, with saturation.
module smab_div #(
  parameter int unsigned GW = 7
) (
  input  logic                          clk_i,
  input  logic                          init_i,
  input  logic                          step_i,
  input  logic [GW-1:0]                 cell_i,
  input  logic [smab_pkg::FRAC_W-1:0]   off_i,
  input  logic [GW-1:0]                 grid_i,
  output logic [smab_pkg::FRAC_W-1:0]   quot_o
);

  logic [GW-1:0]               rem_q;
  logic [GW-1:0]               grid_q;
  logic [smab_pkg::FRAC_W-1:0] off_q;
  logic [smab_pkg::FRAC_W-1:0] quot_q;
  logic                        sat_q;
  logic [GW:0]                 rem_ext;
  logic [GW:0]                 rem_sub;
  logic                        fits;

  always_comb begin
    rem_ext = {rem_q, off_q[smab_pkg::FRAC_W-1]};
    fits    = rem_ext >= (GW+1)'(grid_q);
    rem_sub = rem_ext - (GW+1)'(grid_q);
  end

  always_ff @(posedge clk_i) begin
    if (init_i) begin
      rem_q  <= cell_i;
      grid_q <= grid_i;
      off_q  <= off_i;
      quot_q <= '0;
      sat_q  <= cell_i >= grid_i;
    end else if (step_i) begin
      rem_q  <= fits ? rem_sub[GW-1:0] : rem_ext[GW-1:0];
      off_q  <= {off_q[smab_pkg::FRAC_W-2:0], 1'b0};
      quot_q <= {quot_q[smab_pkg::FRAC_W-2:0], fits};
    end
  end

  assign quot_o = sat_q ? '1 : quot_q;

endmodule

>>> hw/rtl/smab_dp.sv
// Datapath: grid register, raster counters, running argmax, snapshot and dividers.
module smab_dp #(
  parameter int unsigned MAX_GRID = smab_pkg::MAX_GRID_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smab_pkg::dp_cmd_t                   cmd_i,
  output smab_pkg::dp_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic        [smab_pkg::GRID_W-1:0]  cfg_grid_i,
  input  logic signed [smab_pkg::SCORE_W-1:0] cell_score_i,
  input  logic        [smab_pkg::FRAC_W-1:0]  cell_width_i,
  input  logic        [smab_pkg::FRAC_W-1:0]  cell_height_i,
  input  logic        [smab_pkg::FRAC_W-1:0]  cell_offset_x_i,
  input  logic        [smab_pkg::FRAC_W-1:0]  cell_offset_y_i,
  output logic        [smab_pkg::FRAC_W-1:0]  center_x_o,
  output logic        [smab_pkg::FRAC_W-1:0]  center_y_o,
  output logic        [smab_pkg::FRAC_W-1:0]  box_width_o,
  output logic        [smab_pkg::FRAC_W-1:0]  box_height_o,
  output logic signed [smab_pkg::SCORE_W-1:0] peak_score_o,
  output logic        [smab_pkg::IDX_W-1:0]   peak_index_o
);

  localparam int unsigned CW   = $clog2(MAX_GRID);
  localparam int unsigned GW   = $clog2(MAX_GRID + 1);
  localparam int unsigned CMPW = (GW > smab_pkg::GRID_W) ? GW : smab_pkg::GRID_W;
  localparam int unsigned IDXW = CW + GW;

  logic [smab_pkg::GRID_W-1:0] grid_q;
  logic [GW-1:0]               g_eff;

  logic [CW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          have_first_q;
  logic          col_end;
  logic          row_end;
  logic          take;

  logic signed [smab_pkg::SCORE_W-1:0] best_score_q;
  logic [CW-1:0]                       best_row_q;
  logic [CW-1:0]                       best_col_q;
  logic [smab_pkg::FRAC_W-1:0]         best_w_q;
  logic [smab_pkg::FRAC_W-1:0]         best_h_q;
  logic [smab_pkg::FRAC_W-1:0]         best_offx_q;
  logic [smab_pkg::FRAC_W-1:0]         best_offy_q;

  logic signed [smab_pkg::SCORE_W-1:0] sel_score;
  logic [CW-1:0]                       sel_row;
  logic [CW-1:0]                       sel_col;
  logic [smab_pkg::FRAC_W-1:0]         sel_w;
  logic [smab_pkg::FRAC_W-1:0]         sel_h;
  logic [smab_pkg::FRAC_W-1:0]         sel_offx;
  logic [smab_pkg::FRAC_W-1:0]         sel_offy;

  logic signed [smab_pkg::SCORE_W-1:0] sn_score_q;
  logic [CW-1:0]                       sn_row_q;
  logic [CW-1:0]                       sn_col_q;
  logic [GW-1:0]                       sn_g_q;
  logic [smab_pkg::FRAC_W-1:0]         sn_w_q;
  logic [smab_pkg::FRAC_W-1:0]         sn_h_q;
  logic [smab_pkg::IDX_W-1:0]          idx_q;

  logic [IDXW-1:0]                     idx_full;
  logic [IDXW+smab_pkg::IDX_W-1:0]     idx_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= smab_pkg::GRID_RST;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_grid_i;
    end
  end

  always_comb begin
    if (grid_q == '0) begin
      g_eff = GW'(1);
    end else if (CMPW'(grid_q) > CMPW'(MAX_GRID)) begin
      g_eff = GW'(MAX_GRID);
    end else begin
      g_eff = GW'(grid_q);
    end
  end

  always_comb begin
    col_end   = ((GW+1)'(col_q) + (GW+1)'(1)) >= (GW+1)'(g_eff);
    row_end   = ((GW+1)'(row_q) + (GW+1)'(1)) >= (GW+1)'(g_eff);
    take      = !have_first_q || (cell_score_i > best_score_q);
    sel_score = take ? cell_score_i    : best_score_q;
    sel_row   = take ? row_q           : best_row_q;
    sel_col   = take ? col_q           : best_col_q;
    sel_w     = take ? cell_width_i    : best_w_q;
    sel_h     = take ? cell_height_i   : best_h_q;
    sel_offx  = take ? cell_offset_x_i : best_offx_q;
    sel_offy  = take ? cell_offset_y_i : best_offy_q;
  end

  assign status_o.last_cell = col_end && row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      have_first_q <= 1'b0;
    end else if (cmd_i.take_cell) begin
      if (cmd_i.snap) begin
        row_q        <= '0;
        col_q        <= '0;
        have_first_q <= 1'b0;
      end else begin
        have_first_q <= 1'b1;
        if (col_end) begin
          col_q <= '0;
          row_q <= row_q + CW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_cell && take) begin
      best_score_q <= cell_score_i;
      best_row_q   <= row_q;
      best_col_q   <= col_q;
      best_w_q     <= cell_width_i;
      best_h_q     <= cell_height_i;
      best_offx_q  <= cell_offset_x_i;
      best_offy_q  <= cell_offset_y_i;
    end
    if (cmd_i.snap) begin
      sn_score_q <= sel_score;
      sn_row_q   <= sel_row;
      sn_col_q   <= sel_col;
      sn_g_q     <= g_eff;
      sn_w_q     <= sel_w;
      sn_h_q     <= sel_h;
    end
    if (cmd_i.div_step) begin
      idx_q <= idx_wide[smab_pkg::IDX_W-1:0];
    end
  end

  always_comb begin
    idx_full = IDXW'(sn_row_q) * IDXW'(sn_g_q) + IDXW'(sn_col_q);
    idx_wide = (IDXW+smab_pkg::IDX_W)'(idx_full);
  end

  smab_div #(
    .GW (GW)
  ) u_div_x (
    .clk_i  (clk_i),
    .init_i (cmd_i.snap),
    .step_i (cmd_i.div_step),
    .cell_i (GW'(sel_col)),
    .off_i  (sel_offx),
    .grid_i (g_eff),
    .quot_o (center_x_o)
  );

  smab_div #(
    .GW (GW)
  ) u_div_y (
    .clk_i  (clk_i),
    .init_i (cmd_i.snap),
    .step_i (cmd_i.div_step),
    .cell_i (GW'(sel_row)),
    .off_i  (sel_offy),
    .grid_i (g_eff),
    .quot_o (center_y_o)
  );

  assign box_width_o  = sn_w_q;
  assign box_height_o = sn_h_q;
  assign peak_score_o = sn_score_q;
  assign peak_index_o = idx_q;

endmodule

>>> hw/rtl/smab_ctrl.sv
// Controller: cell acceptance, divide sequencing and result handshake.
module smab_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  smab_pkg::dp_status_t status_i,
  output smab_pkg::dp_cmd_t    cmd_o
);

  smab_pkg::state_e             state_q;
  smab_pkg::state_e             state_d;
  logic [smab_pkg::STEP_W-1:0]  step_q;
  logic [smab_pkg::STEP_W-1:0]  step_d;

  always_comb begin
    in_ready_o      = !status_i.last_cell || (state_q == smab_pkg::ST_IDLE);
    cmd_o.take_cell = in_valid_i && in_ready_o;
    cmd_o.snap      = cmd_o.take_cell && status_i.last_cell;
    cmd_o.div_step  = state_q == smab_pkg::ST_DIV;
    out_valid_o     = state_q == smab_pkg::ST_OUT;
  end

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      smab_pkg::ST_IDLE: begin
        if (cmd_o.snap) begin
          state_d = smab_pkg::ST_DIV;
        end
      end
      smab_pkg::ST_DIV: begin
        step_d = step_q + smab_pkg::STEP_W'(1);
        if (step_q == smab_pkg::STEP_LAST) begin
          state_d = smab_pkg::ST_OUT;
        end
      end
      smab_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = smab_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smab_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smab_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

>>> hw/rtl/score_map_argmax_box_decode_unit.sv
// Top level of the score map argmax box decode unit.
//
//   channel  dir  what one beat carries
//   cell_i   in   one map cell: score, width, height, x and y offsets
//   box_o    out  one decoded box per map: centers, sizes, peak score and index
//   cfg_i    in   grid size register write (always ready)
//
// A cell that does not close a map is never held off, also while a box waits.
// The closing cell is taken only when no box is in flight; the centers then pass
// through the bit-serial divider before the box beat is offered.
// Reset sets grid size 16 and starts an empty map; there is no clearing pass.
// A stalled box beat holds the closing cell of the next map at the input.
`include "score_map_argmax_box_decode_unit_assert.svh"

module score_map_argmax_box_decode_unit #(
  parameter int unsigned MAX_GRID = smab_pkg::MAX_GRID_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smab_cell_if.sink   cell_i,
  smab_box_if.source  box_o,
  smab_cfg_if.sink    cfg_i
);

  smab_pkg::dp_cmd_t    cmd;
  smab_pkg::dp_status_t status;

  assign cfg_i.ready = 1'b1;

  smab_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cell_i.valid),
    .in_ready_o  (cell_i.ready),
    .out_valid_o (box_o.valid),
    .out_ready_i (box_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smab_dp #(
    .MAX_GRID (MAX_GRID)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_grid_i      (cfg_i.grid_size),
    .cell_score_i    (cell_i.cell_score),
    .cell_width_i    (cell_i.cell_width),
    .cell_height_i   (cell_i.cell_height),
    .cell_offset_x_i (cell_i.cell_offset_x),
    .cell_offset_y_i (cell_i.cell_offset_y),
    .center_x_o      (box_o.center_x),
    .center_y_o      (box_o.center_y),
    .box_width_o     (box_o.box_width),
    .box_height_o    (box_o.box_height),
    .peak_score_o    (box_o.peak_score),
    .peak_index_o    (box_o.peak_index)
  );

  `SMAB_ASSERT_NEXT(a_snap_no_box, clk_i, rst_ni, cmd.snap, !box_o.valid)
  `SMAB_ASSERT_NEXT(a_box_drop, clk_i, rst_ni, box_o.valid && box_o.ready, !box_o.valid)
  `SMAB_ASSERT_IMPL(a_last_held, clk_i, rst_ni, status.last_cell && box_o.valid, !cell_i.ready)

endmodule

>>> tb/tb.sv
// Self-checking testbench of the score map argmax box decode unit.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned SETTLE_CYC = 40;
  localparam int unsigned QUIET_FROM = 1200;
  localparam int unsigned QUIET_TO   = 2400;
  localparam int unsigned RAND_CELLS = 1460;
  localparam int unsigned BIG_GRID   = smab_pkg::MAX_GRID_DEF;

  typedef struct packed {
    logic signed [smab_pkg::SCORE_W-1:0] score;
    logic [smab_pkg::FRAC_W-1:0]         width;
    logic [smab_pkg::FRAC_W-1:0]         height;
    logic [smab_pkg::FRAC_W-1:0]         off_x;
    logic [smab_pkg::FRAC_W-1:0]         off_y;
  } cell_t;

  typedef struct packed {
    logic [smab_pkg::FRAC_W-1:0]         center_x;
    logic [smab_pkg::FRAC_W-1:0]         center_y;
    logic [smab_pkg::FRAC_W-1:0]         box_width;
    logic [smab_pkg::FRAC_W-1:0]         box_height;
    logic signed [smab_pkg::SCORE_W-1:0] peak_score;
    logic [smab_pkg::IDX_W-1:0]          peak_index;
  } box_t;

  typedef enum int unsigned {
    SC_WIDE,
    SC_NARROW,
    SC_EXTREME
  } score_mode_e;

  logic clk_i;
  logic rst_ni;

  smab_cell_if cell_if ();
  smab_box_if  box_if ();
  smab_cfg_if  cfg_if ();

  score_map_argmax_box_decode_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (cell_if),
    .box_o  (box_if),
    .cfg_i  (cfg_if)
  );

  // map tracker state
  logic [smab_pkg::GRID_W-1:0]         grid_reg;
  logic signed [smab_pkg::SCORE_W-1:0] kp_score;
  logic [5:0]                          kp_row;
  logic [5:0]                          kp_col;
  logic [smab_pkg::FRAC_W-1:0]         kp_width;
  logic [smab_pkg::FRAC_W-1:0]         kp_height;
  logic [smab_pkg::FRAC_W-1:0]         kp_off_x;
  logic [smab_pkg::FRAC_W-1:0]         kp_off_y;
  logic [5:0]                          scan_row;
  logic [5:0]                          scan_col;
  bit                                  kp_valid;

  cell_t       cell_pending[$];
  box_t        box_expect[$];
  cell_t       drv_cell;
  int unsigned cyc;
  int unsigned mismatch_cnt;
  int unsigned cells_taken;
  int unsigned boxes_checked;
  int unsigned cfg_writes;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void clear_map();
    kp_score  = 16'sh8000;
    kp_row    = '0;
    kp_col    = '0;
    kp_width  = '0;
    kp_height = '0;
    kp_off_x  = '0;
    kp_off_y  = '0;
    scan_row  = '0;
    scan_col  = '0;
    kp_valid  = 1'b0;
  endfunction

  function automatic logic [smab_pkg::FRAC_W-1:0] center_of(logic [5:0] pos,
                                                            logic [smab_pkg::FRAC_W-1:0] frac,
                                                            int unsigned g);
    logic [63:0] q;
    q = {42'd0, pos, 16'd0} + {48'd0, frac};
    q = q / g;
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic void take_cell(cell_t c);
    int unsigned g;
    int unsigned idx;
    bit          closed;
    box_t        b;
    g = (grid_reg < 1) ? 1 : ((grid_reg > BIG_GRID) ? BIG_GRID : int'(grid_reg));
    closed = 1'b0;
    if (!kp_valid || c.score > kp_score) begin
      kp_score  = c.score;
      kp_row    = scan_row;
      kp_col    = scan_col;
      kp_width  = c.width;
      kp_height = c.height;
      kp_off_x  = c.off_x;
      kp_off_y  = c.off_y;
      kp_valid  = 1'b1;
    end
    if (int'(scan_col) + 1 >= g) begin
      scan_col = '0;
      if (int'(scan_row) + 1 >= g) closed = 1'b1;
      else scan_row = scan_row + 1'b1;
    end else begin
      scan_col = scan_col + 1'b1;
    end
    if (closed) begin
      idx          = int'(kp_row) * g + int'(kp_col);
      b.center_x   = center_of(kp_col, kp_off_x, g);
      b.center_y   = center_of(kp_row, kp_off_y, g);
      b.box_width  = kp_width;
      b.box_height = kp_height;
      b.peak_score = kp_score;
      b.peak_index = idx[smab_pkg::IDX_W-1:0];
      box_expect   = {box_expect, b};
      clear_map();
    end
  endfunction

  function automatic bit hold_off();
    if (cyc >= QUIET_FROM && cyc < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 6;
  endfunction

  function automatic void check_field(string name, logic [smab_pkg::FRAC_W-1:0] want,
                                      logic [smab_pkg::FRAC_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  function automatic cell_t rand_cell(score_mode_e mode);
    cell_t c;
    c.width  = 16'($urandom);
    c.height = 16'($urandom);
    c.off_x  = 16'($urandom);
    c.off_y  = 16'($urandom);
    case (mode)
      SC_NARROW:  c.score = 16'(int'($urandom_range(4)) - 2);
      SC_EXTREME: c.score = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default:    c.score = 16'($urandom);
    endcase
    return c;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // cell driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_if.valid         <= 1'b0;
      cell_if.cell_score    <= '0;
      cell_if.cell_width    <= '0;
      cell_if.cell_height   <= '0;
      cell_if.cell_offset_x <= '0;
      cell_if.cell_offset_y <= '0;
    end else if (!cell_if.valid || cell_if.ready) begin
      if (cell_pending.size() != 0 && !hold_off()) begin
        drv_cell = cell_pending.pop_front();
        cell_if.valid         <= 1'b1;
        cell_if.cell_score    <= drv_cell.score;
        cell_if.cell_width    <= drv_cell.width;
        cell_if.cell_height   <= drv_cell.height;
        cell_if.cell_offset_x <= drv_cell.off_x;
        cell_if.cell_offset_y <= drv_cell.off_y;
      end else begin
        cell_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) box_if.ready <= 1'b0;
    else box_if.ready <= !hold_off();
  end

  // cell monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_map();
    end else if (cell_if.valid && cell_if.ready) begin
      take_cell(cell_t'{score: cell_if.cell_score, width: cell_if.cell_width,
                        height: cell_if.cell_height, off_x: cell_if.cell_offset_x,
                        off_y: cell_if.cell_offset_y});
      cells_taken++;
    end
  end

  // box monitor
  always @(posedge clk_i) begin
    box_t want;
    if (rst_ni && box_if.valid && box_if.ready) begin
      if (box_expect.size() == 0) begin
        $error("box beat with no map closed: center_x %h, peak_index %h",
               box_if.center_x, box_if.peak_index);
        mismatch_cnt++;
      end else begin
        want = box_expect.pop_front();
        check_field("center_x", want.center_x, box_if.center_x);
        check_field("center_y", want.center_y, box_if.center_y);
        check_field("box_width", want.box_width, box_if.box_width);
        check_field("box_height", want.box_height, box_if.box_height);
        check_field("peak_score", want.peak_score, box_if.peak_score);
        check_field("peak_index", 16'(want.peak_index), 16'(box_if.peak_index));
        boxes_checked++;
      end
    end
  end

  task automatic settle();
    while (cell_pending.size() != 0 || cell_if.valid || box_expect.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_grid(input logic [smab_pkg::GRID_W-1:0] v);
    @(posedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.grid_size <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    grid_reg = v;
    cfg_writes++;
  endtask

  task automatic queue_cell(input logic [15:0] s, input logic [15:0] w, input logic [15:0] h,
                            input logic [15:0] x, input logic [15:0] y);
    cell_pending = {cell_pending, cell_t'{score: s, width: w, height: h, off_x: x, off_y: y}};
  endtask

  initial begin
    int unsigned pick;
    int unsigned g;
    int unsigned eg;
    int unsigned n;
    int unsigned small_cells;
    score_mode_e mode;
    cell_t       c;

    cfg_if.valid     = 1'b0;
    cfg_if.grid_size = '0;
    cfg_writes       = 0;
    small_cells      = 0;
    grid_reg         = smab_pkg::GRID_RST;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-cell maps at the field extremes
    write_grid(7'd1);
    queue_cell(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cell(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    settle();

    // zero grid size acts as one
    write_grid(7'd0);
    queue_cell(16'h0001, 16'h1234, 16'h8000, 16'h8000, 16'h7FFF);
    queue_cell(16'hFFFF, 16'hA5A5, 16'h5A5A, 16'h0001, 16'hFFFE);
    settle();

    // ties keep the first cell; most negative scores; late winner
    write_grid(7'd2);
    for (int i = 0; i < 4; i++) queue_cell(16'h0100, 16'(i + 1), 16'(i + 2), 16'h1000, 16'h2000);
    for (int i = 0; i < 4; i++) queue_cell(16'h8000, 16'(i + 7), 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_cell(16'h8000, 16'h0011, 16'h0022, 16'h0033, 16'h0044);
    queue_cell(16'h0000, 16'h0055, 16'h0066, 16'h0077, 16'h0088);
    queue_cell(16'h0001, 16'h0099, 16'h00AA, 16'h00BB, 16'h00CC);
    queue_cell(16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
    settle();

    // shrink the grid mid-map so the kept row lies beyond it
    write_grid(7'd4);
    for (int i = 0; i < 9; i++) queue_cell(16'(i), 16'(i), 16'(i), 16'(i), 16'(i));
    queue_cell(16'h7FFF, 16'hBEEF, 16'hCAFE, 16'h4000, 16'hFFFF);
    settle();
    write_grid(7'd2);
    queue_cell(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    settle();

    // open a map at the largest grid, carry on with an oversize register, close it small
    write_grid(smab_pkg::GRID_W'(BIG_GRID));
    for (int i = 0; i < 100; i++) cell_pending = {cell_pending, rand_cell(SC_WIDE)};
    settle();
    write_grid(7'h7F);
    for (int i = 0; i < 60; i++) cell_pending = {cell_pending, rand_cell(SC_WIDE)};
    settle();
    write_grid(7'd3);
    c = rand_cell(SC_WIDE);
    c.score = 16'sh8000;
    cell_pending = {cell_pending, c};
    settle();

    while (small_cells < RAND_CELLS) begin
      pick = $urandom_range(99);
      if (pick < 60) g = $urandom_range(1, 6);
      else if (pick < 90) g = $urandom_range(7, 16);
      else if (pick < 95) g = 0;
      else g = $urandom_range(17, 24);
      write_grid(smab_pkg::GRID_W'(g));
      eg = (g == 0) ? 1 : g;
      n = ((eg > 8) ? 1 : $urandom_range(1, 4)) * eg * eg;
      // leave a map open now and then
      if ($urandom_range(4) == 0) n += $urandom_range(1, eg * eg);
      mode = score_mode_e'($urandom_range(2));
      for (int i = 0; i < n; i++) cell_pending = {cell_pending, rand_cell(mode)};
      small_cells += n;
      settle();
    end

    $display("%0d cells taken, %0d boxes checked across %0d grid size writes",
             cells_taken, boxes_checked, cfg_writes);
    if (mismatch_cnt == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
